[design/zlhp_pkg.sv]
// Types and constants shared by the ZIP local header parser modules.
package zlhp_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_EXTRA  = 2'd2,
    PH_DATA   = 2'd3
  } phase_t;

  localparam logic [1:0] KIND_BEGIN = 2'd0;
  localparam logic [1:0] KIND_NAME  = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  localparam logic [1:0] STOP_NO_ROOM   = 2'd0;
  localparam logic [1:0] STOP_BAD_SIG   = 2'd1;
  localparam logic [1:0] STOP_TRUNCATED = 2'd2;

  localparam int unsigned HDR_BYTES = 30;
  localparam int unsigned SIG_BYTES = 4;

  localparam logic [4:0] HDR_SIZE_B0  = 5'd18;
  localparam logic [4:0] HDR_SIZE_B1  = 5'd19;
  localparam logic [4:0] HDR_SIZE_B2  = 5'd20;
  localparam logic [4:0] HDR_SIZE_B3  = 5'd21;
  localparam logic [4:0] HDR_SUM_BASE = 5'd22;
  localparam logic [4:0] HDR_NAME_LO  = 5'd26;
  localparam logic [4:0] HDR_NAME_HI  = 5'd27;
  localparam logic [4:0] HDR_EXTRA_LO = 5'd28;
  localparam logic [4:0] HDR_EXTRA_HI = 5'd29;

  localparam logic [3:0][7:0] SIG = {8'h04, 8'h03, 8'h4B, 8'h50};

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [15:0] name_length;
    logic [31:0] data_size;
    logic [27:0] entry_number;
    logic        field_last;
    logic [1:0]  stop_reason;
    logic        last_result;
  } res_t;

  typedef struct packed {
    logic p0;
    logic p1;
  } push_t;

  typedef struct packed {
    logic nempty;
    logic near_full;
  } q_stat_t;

endpackage

[design/zlhp_front.sv]
// Parser front end: walks local headers and forms up to two results per byte.
module zlhp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_accept,
  input  logic [7:0]         in_byte,
  output zlhp_pkg::push_t    push,
  output zlhp_pkg::res_t     res0,
  output zlhp_pkg::res_t     res1
);

  localparam logic [31:0] SUM_OFFSET =
    32'(zlhp_pkg::HDR_BYTES - 32'(zlhp_pkg::HDR_SIZE_B3) - 1);

  zlhp_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [15:0] nl_r, nl_nxt;
  logic [15:0] el_r, el_nxt;
  logic [31:0] ds_r, ds_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [27:0] ec_r, ec_nxt;
  logic        stopped_r, stopped_nxt;
  logic [31:0] len_r, len_nxt;
  logic [33:0] sum_r, sum_nxt;

  logic        active, hdr, early_stop, sig_bad, cap_en, hdr_done, trunc;
  logic        fld_last, do_adv, go_name, go_ext, go_data, finish, fin_stop, room_fail;
  logic        emit_byte, has0, has1;
  logic [31:0] room_base, pos_plus;
  logic [33:0] hdr_end;
  logic [27:0] ec_inc;

  assign active     = in_accept && !stopped_r;
  assign hdr        = (phase_r == zlhp_pkg::PH_HEADER);
  assign room_base  = (hdr && idx_r == '0) ? pos_r : pos_r + 32'd1;
  assign room_fail  = ({1'b0, room_base} + 33'(zlhp_pkg::HDR_BYTES)) > {1'b0, len_r};
  assign early_stop = hdr && idx_r == '0 && room_fail;
  assign sig_bad    = hdr && !early_stop && idx_r < 5'(zlhp_pkg::SIG_BYTES) &&
                      in_byte != zlhp_pkg::SIG[idx_r[1:0]];
  assign cap_en     = active && hdr && !early_stop && !sig_bad;
  assign hdr_done   = hdr && !early_stop && idx_r == zlhp_pkg::HDR_EXTRA_HI;
  assign hdr_end    = sum_r + {18'd0, in_byte, 8'd0};
  assign trunc      = hdr_done && hdr_end > {2'b00, len_r};
  assign fld_last   = !hdr && rem_r <= 32'd1;
  assign do_adv     = (hdr_done && !trunc) || fld_last;
  assign go_name    = phase_r < zlhp_pkg::PH_NAME && nl_nxt != '0;
  assign go_ext     = !go_name && phase_r < zlhp_pkg::PH_EXTRA && el_nxt != '0;
  assign go_data    = !go_name && !go_ext && phase_r < zlhp_pkg::PH_DATA && ds_nxt != '0;
  assign finish     = do_adv && !go_name && !go_ext && !go_data;
  assign fin_stop   = finish && room_fail;
  assign emit_byte  = !hdr && phase_r != zlhp_pkg::PH_EXTRA;
  assign ec_inc     = ec_r + 28'd1;
  assign pos_plus   = pos_r + SUM_OFFSET;

  // Header field capture and the running end-of-entry sum
  always_comb begin
    nl_nxt  = nl_r;
    el_nxt  = el_r;
    ds_nxt  = ds_r;
    sum_nxt = sum_r;
    if (cap_en) begin
      case (idx_r)
        zlhp_pkg::HDR_SIZE_B0:  ds_nxt[7:0]   = in_byte;
        zlhp_pkg::HDR_SIZE_B1:  ds_nxt[15:8]  = in_byte;
        zlhp_pkg::HDR_SIZE_B2:  ds_nxt[23:16] = in_byte;
        zlhp_pkg::HDR_SIZE_B3:  ds_nxt[31:24] = in_byte;
        zlhp_pkg::HDR_SUM_BASE: sum_nxt = {2'b00, pos_plus} + {2'b00, ds_r};
        zlhp_pkg::HDR_NAME_LO:  nl_nxt[7:0]   = in_byte;
        zlhp_pkg::HDR_NAME_HI: begin
          nl_nxt[15:8] = in_byte;
          sum_nxt      = sum_r + {18'd0, in_byte, nl_r[7:0]};
        end
        zlhp_pkg::HDR_EXTRA_LO: begin
          el_nxt[7:0] = in_byte;
          sum_nxt     = sum_r + {26'd0, in_byte};
        end
        zlhp_pkg::HDR_EXTRA_HI: el_nxt[15:8] = in_byte;
        default: ;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (active && do_adv) begin
      if (go_name) begin
        phase_nxt = zlhp_pkg::PH_NAME;
      end else if (go_ext) begin
        phase_nxt = zlhp_pkg::PH_EXTRA;
      end else if (go_data) begin
        phase_nxt = zlhp_pkg::PH_DATA;
      end else begin
        phase_nxt = zlhp_pkg::PH_HEADER;
      end
    end
  end

  // Counters and flags
  always_comb begin
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    rem_nxt     = rem_r;
    ec_nxt      = ec_r;
    stopped_nxt = stopped_r;
    len_nxt     = cfg_wr_en ? cfg_wr_data : len_r;
    if (active) begin
      pos_nxt = pos_r + 32'd1;
      if (cap_en) begin
        idx_nxt = hdr_done ? '0 : idx_r + 5'd1;
      end
      if (!hdr) begin
        rem_nxt = fld_last ? '0 : rem_r - 32'd1;
      end
      if (do_adv) begin
        if (go_name) begin
          rem_nxt = {16'd0, nl_nxt};
        end else if (go_ext) begin
          rem_nxt = {16'd0, el_nxt};
        end else if (go_data) begin
          rem_nxt = ds_nxt;
        end
      end
      if (finish) begin
        ec_nxt  = ec_inc;
        idx_nxt = '0;
      end
      if (early_stop || sig_bad || trunc || fin_stop) begin
        stopped_nxt = 1'b1;
      end
    end
  end

  // Result formation
  always_comb begin
    res0 = '0;
    res1 = '0;
    has0 = 1'b0;
    has1 = 1'b0;
    if (early_stop || sig_bad || trunc) begin
      has0              = 1'b1;
      res0.kind         = zlhp_pkg::KIND_END;
      res0.entry_number = ec_r;
      res0.stop_reason  = early_stop ? zlhp_pkg::STOP_NO_ROOM :
                          sig_bad    ? zlhp_pkg::STOP_BAD_SIG : zlhp_pkg::STOP_TRUNCATED;
    end else if (hdr_done) begin
      has0              = 1'b1;
      res0.kind         = zlhp_pkg::KIND_BEGIN;
      res0.name_length  = nl_nxt;
      res0.data_size    = ds_nxt;
      res0.entry_number = ec_r;
    end else if (emit_byte) begin
      has0              = 1'b1;
      res0.kind         = (phase_r == zlhp_pkg::PH_NAME) ? zlhp_pkg::KIND_NAME
                                                         : zlhp_pkg::KIND_DATA;
      res0.byte_value   = in_byte;
      res0.entry_number = ec_r;
      res0.field_last   = fld_last;
    end else if (fin_stop) begin
      has0              = 1'b1;
      res0.kind         = zlhp_pkg::KIND_END;
      res0.entry_number = ec_inc;
      res0.stop_reason  = zlhp_pkg::STOP_NO_ROOM;
    end
    if ((hdr_done || emit_byte) && !trunc && fin_stop) begin
      has1              = 1'b1;
      res1.kind         = zlhp_pkg::KIND_END;
      res1.entry_number = ec_inc;
      res1.stop_reason  = zlhp_pkg::STOP_NO_ROOM;
      res1.last_result  = 1'b1;
    end
    res0.last_result = !has1;
    push.p0 = active && has0;
    push.p1 = active && has1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= zlhp_pkg::PH_HEADER;
      idx_r     <= '0;
      pos_r     <= '0;
      nl_r      <= '0;
      el_r      <= '0;
      ds_r      <= '0;
      rem_r     <= '0;
      ec_r      <= '0;
      stopped_r <= 1'b0;
      len_r     <= '0;
      sum_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      pos_r     <= pos_nxt;
      nl_r      <= nl_nxt;
      el_r      <= el_nxt;
      ds_r      <= ds_nxt;
      rem_r     <= rem_nxt;
      ec_r      <= ec_nxt;
      stopped_r <= stopped_nxt;
      len_r     <= len_nxt;
      sum_r     <= sum_nxt;
    end
  end

`ifndef SYNTHESIS
  a_silent_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> !push.p0) else $error("result pushed after parse stop");
  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.p1 |-> (push.p0 && res1.kind == zlhp_pkg::KIND_END))
    else $error("second result without first or not an end result");
  a_stop_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r) else $error("stop flag cleared");
  a_header_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    !hdr |-> idx_r == '0) else $error("header index set outside header phase");
`endif

endmodule

[design/zlhp_queue.sv]
// Short result queue between parser and output stage, two writes and one read per cycle.
module zlhp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  zlhp_pkg::push_t    push,
  input  zlhp_pkg::res_t     res0,
  input  zlhp_pkg::res_t     res1,
  input  logic               pop,
  output zlhp_pkg::res_t     head,
  output zlhp_pkg::q_stat_t  stat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  zlhp_pkg::res_t mem_r [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt, wr1;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr1            = inc_ptr(wr_r);
  assign head           = mem_r[rd_r];
  assign stat.nempty    = (cnt_r != '0);
  assign stat.near_full = (cnt_r >= CW'(DEPTH - 1));

  always_comb begin
    wr_nxt  = push.p1 ? inc_ptr(wr1) : (push.p0 ? wr1 : wr_r);
    rd_nxt  = pop ? inc_ptr(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(push.p0) + CW'(push.p1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.p0) begin
      mem_r[wr_r] <= res0;
    end
    if (push.p1) begin
      mem_r[wr1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
    stat.near_full |-> !push.p0) else $error("push into nearly full queue");
  a_pop_when_filled: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.nempty) else $error("pop from empty queue");
`endif

endmodule

[design/zlhp_back.sv]
// Output stage: registers one queued result and holds it while the receiver stalls.
module zlhp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  zlhp_pkg::q_stat_t  stat,
  input  zlhp_pkg::res_t     head,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output zlhp_pkg::res_t     out_res
);

  logic           vld_r, vld_nxt;
  zlhp_pkg::res_t res_r, res_nxt;

  assign pop       = stat.nempty && (!vld_r || !out_stall);
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_comb begin
    res_nxt = pop ? head : res_r;
    vld_nxt = pop || (vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && out_stall) |=> (vld_r && $stable(res_r)))
    else $error("output result changed under stall");
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && out_stall) |-> !pop) else $error("queue popped while output held");
  a_fill_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (!vld_r && stat.nempty) |=> vld_r) else $error("pending result not loaded");
`endif

endmodule

[design/zip_local_header_parser_top.sv]
// Top level of the ZIP local header parser.
// Usage:
//   Write the archive length through cfg_wr_en / cfg_wr_data while idle, then
//   present archive bytes in order on in_archive_byte with in_valid. A byte
//   transfers at an edge where in_valid is high and in_stall is low.
//   Results leave on the out_ channel, one per transfer: entry begin, name
//   bytes, data bytes and one end result; out_last_result marks the final
//   result caused by a byte. Extra-field bytes give no result.
//   A result is written into the result queue, then registered in the output stage before it is offered.
//   Throughput: one byte per cycle while in_stall is low; the output stage
//   drains one result per cycle, so a byte causing two results leaves one more entry in the queue.
//   The result queue (QUEUE_DEPTH entries) sets in_stall: it rises when fewer
//   than two entries are free.
//   When the receiver raises out_stall the held result stays, the queue fills,
//   and in_stall rises soon after.
//   Reset (rst_n low, synchronous) empties the queue, clears the parse state
//   and sets the archive length to zero.
//   After the end result further bytes are taken and dropped.
module zip_local_header_parser_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_archive_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte_value,
  output logic [15:0] out_name_length,
  output logic [31:0] out_data_size,
  output logic [27:0] out_entry_number,
  output logic        out_field_last,
  output logic [1:0]  out_stop_reason,
  output logic        out_last_result
);

  zlhp_pkg::push_t   push;
  zlhp_pkg::res_t    res0, res1, head, out_res;
  zlhp_pkg::q_stat_t stat;
  logic              pop;
  logic              in_accept;

  assign in_stall  = stat.near_full;
  assign in_accept = in_valid && !in_stall;

  zlhp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_accept   (in_accept),
    .in_byte     (in_archive_byte),
    .push        (push),
    .res0        (res0),
    .res1        (res1)
  );

  zlhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .res0  (res0),
    .res1  (res1),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  zlhp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (stat),
    .head      (head),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_byte_value   = out_res.byte_value;
  assign out_name_length  = out_res.name_length;
  assign out_data_size    = out_res.data_size;
  assign out_entry_number = out_res.entry_number;
  assign out_field_last   = out_res.field_last;
  assign out_stop_reason  = out_res.stop_reason;
  assign out_last_result  = out_res.last_result;

endmodule
